[rtl/assert_macros.svh]
// Assertion macros shared by the queue RTL.
// Each macro takes a label, the clock, the reset, a trigger and a consequence.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequence must hold in the same cycle as the trigger.
`define SQS_ASSERT_IMPL(label, clk, rst, trig, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) \
      else $error("assertion failed");

// The consequence must hold in the cycle after the trigger.
`define SQS_ASSERT_NEXT(label, clk, rst, trig, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
      else $error("assertion failed");

`endif

[rtl/sqs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqs_pkg
// Types and constants shared by the shifting queue with search.
// ----------------------------------------------------------------------------
package sqs_pkg;

   localparam int DEPTH      = 16;
   localparam int IDX_W      = $clog2(DEPTH);
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int CAP_W      = 5;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
   localparam logic [CSR_ADDR_W-3:0] REG_CAPACITY = '0;

   typedef enum logic [1:0] {
      KIND_ENQUEUE = 2'd0,
      KIND_DEQUEUE = 2'd1,
      KIND_SEARCH  = 2'd2,
      KIND_CLEAR   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_EMPTY     = 2'd2,
      STATUS_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_EXEC   = 2'd1,
      ST_ENCODE = 2'd2
   } state_type;

   typedef struct packed {
      kind_type           kind;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic signed [31:0] data;
      logic [3:0]         position;
      logic signed [31:0] front;
      logic [4:0]         count;
      logic               is_empty;
      logic               is_full;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic execute;
      logic encode;
   } ctrl_cmd_type;

   typedef struct packed {
      logic is_search;
   } dp_stat_type;

endpackage

[rtl/shifting_queue_with_search_core.sv]
// A result word strobes once its command word has been captured and executed;
// a search first spends an extra encode step turning its match vector into a position.
// The core takes no new command word until the previous one has left the execute or encode state.
// Reset clears the entry count and sets capacity to 16; cell contents are not cleared.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shifting_queue_with_search_core
// Front-aligned FIFO of signed 32-bit words with enqueue, dequeue, search and clear.
// ----------------------------------------------------------------------------
module shifting_queue_with_search_core
   import sqs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // Command channel: a word is taken when start is high and busy is low.
   input  logic                  start,
   input  req_type               req_word,
   output logic                  busy,
   // Result channel: each result word is present for exactly one cycle.
   output logic                  rsp_valid,
   output rsp_type               rsp_word,
   // Configuration port.
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   // The controller and the datapath only see each other through these groups.
   ctrl_cmd_type     cmd;
   dp_stat_type      stat;
   logic [CNT_W-1:0] cap_eff;

   // The capacity register supplies an already clamped capacity, so the
   // datapath never has to deal with zero or oversized settings.
   sqs_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cap_eff (cap_eff)
   );

   // The sequencer captures a word in idle, runs it in the execute state and, for a
   // search, adds an encode state that turns the match vector into a position.
   sqs_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .busy  (busy),
      .cmd   (cmd)
   );

   // The datapath holds the cells as a shift register: a dequeue moves every
   // cell down one place at once, and a search compares every held cell
   // against the word at once and registers the match vector.
   sqs_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_word  (req_word),
      .cap_eff   (cap_eff),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

endmodule

[rtl/sqs_csr.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqs_csr
// Capacity register behind an APB-style port, with the clamped capacity.
// ----------------------------------------------------------------------------
module sqs_csr
   import sqs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output logic [CNT_W-1:0]      cap_eff
);

   logic [CAP_W-1:0] cap_ff;
   logic [CAP_W-1:0] cap_in;
   logic             hit;

   assign pready = 1'b1;
   assign hit    = (paddr[CSR_ADDR_W-1:2] == REG_CAPACITY);

   always_comb begin
      cap_in = cap_ff;
      if (psel && penable && pwrite && pready && hit) begin
         cap_in = pwdata[CAP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else begin
         cap_ff <= cap_in;
      end
   end

   assign prdata = hit ? CSR_DATA_W'(cap_ff) : '0;

   // A capacity of zero acts as one; anything above the built depth acts as the depth.
   always_comb begin
      if (cap_ff == '0) begin
         cap_eff = CNT_W'(1);
      end else if (int'(cap_ff) > DEPTH) begin
         cap_eff = CNT_W'(DEPTH);
      end else begin
         cap_eff = CNT_W'(cap_ff);
      end
   end

endmodule

[rtl/sqs_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqs_ctrl
// Sequencer that captures a command word, executes it and encodes searches.
// ----------------------------------------------------------------------------
module sqs_ctrl
   import sqs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  dp_stat_type  stat,
   output logic         busy,
   output ctrl_cmd_type cmd
);
`include "assert_macros.svh"

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.execute = 1'b1;
            state_in    = stat.is_search ? ST_ENCODE : ST_IDLE;
         end
         ST_ENCODE: begin
            cmd.encode = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

   `SQS_ASSERT_NEXT(a_encode_ends, clock, reset, state_ff == ST_ENCODE, state_ff == ST_IDLE)
   `SQS_ASSERT_NEXT(a_plain_op_ends, clock, reset, (state_ff == ST_EXEC) && !stat.is_search, state_ff == ST_IDLE)

endmodule

[rtl/sqs_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqs_dp
// Shift-register cells, entry count, match vector and result register.
// ----------------------------------------------------------------------------
module sqs_dp
   import sqs_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  ctrl_cmd_type     cmd,
   input  req_type          req_word,
   input  logic [CNT_W-1:0] cap_eff,
   output dp_stat_type      stat,
   output logic             rsp_valid,
   output rsp_type          rsp_word
);
`include "assert_macros.svh"

   req_type             req_ff;
   req_type             req_in;
   logic signed [31:0]  cells_ff [DEPTH];
   logic signed [31:0]  cells_in [DEPTH];
   logic [CNT_W-1:0]    held_ff;
   logic [CNT_W-1:0]    held_in;
   logic [DEPTH-1:0]    match_ff;
   logic [DEPTH-1:0]    match_in;
   rsp_type             rsp_ff;
   rsp_type             rsp_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic                full;
   logic                empty;
   logic                found;
   logic [IDX_W-1:0]    hit_pos;
   logic                enq_ok;

   assign full      = (held_ff >= cap_eff);
   assign empty     = (held_ff == '0);
   assign found     = |match_ff;
   assign stat      = '{is_search: (req_ff.kind == KIND_SEARCH)};
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;
   assign enq_ok    = cmd.execute && (req_ff.kind == KIND_ENQUEUE) && !full;

   // Lowest matching position wins.
   always_comb begin
      hit_pos = '0;
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (match_ff[i]) begin
            hit_pos = IDX_W'(i);
         end
      end
   end

   always_comb begin
      req_in       = cmd.capture ? req_word : req_ff;
      cells_in     = cells_ff;
      held_in      = held_ff;
      match_in     = match_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;

      if (cmd.execute) begin
         rsp_in.status   = STATUS_OK;
         rsp_in.data     = '0;
         rsp_in.position = '0;
         case (req_ff.kind)
            KIND_ENQUEUE: begin
               if (full) begin
                  rsp_in.status = STATUS_FULL;
               end else begin
                  cells_in[held_ff[IDX_W-1:0]] = req_ff.value;
                  held_in = held_ff + CNT_W'(1);
               end
            end
            KIND_DEQUEUE: begin
               if (empty) begin
                  rsp_in.status = STATUS_EMPTY;
               end else begin
                  rsp_in.data = cells_ff[0];
                  for (int i = 0; i < DEPTH - 1; i++) begin
                     cells_in[i] = cells_ff[i + 1];
                  end
                  held_in = held_ff - CNT_W'(1);
               end
            end
            KIND_SEARCH: begin
               for (int i = 0; i < DEPTH; i++) begin
                  match_in[i] = (i < int'(held_ff)) && (cells_ff[i] == req_ff.value);
               end
            end
            KIND_CLEAR: begin
               held_in = '0;
            end
            default: begin
               held_in = held_ff;
            end
         endcase
         rsp_in.front    = (held_in != '0) ? cells_in[0] : '0;
         rsp_in.count    = CAP_W'(held_in);
         rsp_in.is_empty = (held_in == '0);
         rsp_in.is_full  = (held_in >= cap_eff);
         rsp_valid_in    = (req_ff.kind != KIND_SEARCH);
      end

      if (cmd.encode) begin
         rsp_in.status   = found ? STATUS_OK : STATUS_NOT_FOUND;
         rsp_in.data     = '0;
         rsp_in.position = found ? 4'(hit_pos) : '0;
         rsp_in.front    = empty ? '0 : cells_ff[0];
         rsp_in.count    = CAP_W'(held_ff);
         rsp_in.is_empty = empty;
         rsp_in.is_full  = full;
         rsp_valid_in    = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      cells_ff <= cells_in;
      match_ff <= match_in;
      rsp_ff   <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `SQS_ASSERT_IMPL(a_held_range, clock, reset, 1'b1, int'(held_ff) <= DEPTH)
   `SQS_ASSERT_NEXT(a_enqueue_grows, clock, reset, enq_ok, held_ff == $past(held_ff) + CNT_W'(1))

endmodule
